// File: design/hchm_pkg.sv
`timescale 1ns / 1ps
package hchm_pkg;

  localparam int SLOT_COUNT_DEF    = 32;
  localparam int BLOCK_ENTRIES_DEF = 65;
  localparam int HEADER_BYTES      = 32;
  localparam int MIN_SPLIT_BYTES   = 8;
  localparam int SPLIT_MIN         = HEADER_BYTES + MIN_SPLIT_BYTES;

  localparam logic [6:0]  ENTRY_NIL     = 7'd127;
  localparam logic [21:0] HEAP_MIN      = 22'd64;
  localparam logic [21:0] HEAP_MAX      = 22'd1048576;
  localparam logic [20:0] HEAP_SIZE_RST = 21'd1048576;

  localparam logic [2:0] CMD_ALLOC  = 3'd0;
  localparam logic [2:0] CMD_FREE   = 3'd1;
  localparam logic [2:0] CMD_DEREF  = 3'd2;
  localparam logic [2:0] CMD_DEFRAG = 3'd3;
  localparam logic [2:0] CMD_INIT   = 3'd4;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_INVALID    = 3'd1;
  localparam logic [2:0] ST_NO_SPACE   = 3'd2;
  localparam logic [2:0] ST_NO_SLOT    = 3'd3;
  localparam logic [2:0] ST_NOT_ACTIVE = 3'd4;

  localparam logic [4:0] OP_NOP        = 5'd0;
  localparam logic [4:0] OP_TAKE       = 5'd1;
  localparam logic [4:0] OP_BUILD      = 5'd2;
  localparam logic [4:0] OP_EMIT       = 5'd3;
  localparam logic [4:0] OP_WALK_INIT  = 5'd4;
  localparam logic [4:0] OP_RD_E       = 5'd5;
  localparam logic [4:0] OP_AF_CHK     = 5'd6;
  localparam logic [4:0] OP_SLOT_STEP  = 5'd7;
  localparam logic [4:0] OP_SPARE_STEP = 5'd8;
  localparam logic [4:0] OP_SPLIT      = 5'd9;
  localparam logic [4:0] OP_ACOMMIT    = 5'd10;
  localparam logic [4:0] OP_EMIT_ALLOC = 5'd11;
  localparam logic [4:0] OP_RD_SLOT    = 5'd12;
  localparam logic [4:0] OP_EMIT_DEREF = 5'd13;
  localparam logic [4:0] OP_FREE_WR    = 5'd14;
  localparam logic [4:0] OP_C_LAT      = 5'd15;
  localparam logic [4:0] OP_C_CHK      = 5'd16;
  localparam logic [4:0] OP_D_LAT      = 5'd17;
  localparam logic [4:0] OP_D_FREE     = 5'd18;
  localparam logic [4:0] OP_EMIT_MOVE  = 5'd19;
  localparam logic [4:0] OP_D_UPD      = 5'd20;
  localparam logic [4:0] OP_D_TAIL     = 5'd21;
  localparam logic [4:0] OP_D_FWR      = 5'd22;
  localparam logic [4:0] OP_D_LINK     = 5'd23;

  typedef struct packed {
    logic [2:0]  command;
    logic [20:0] request_size;
    logic [5:0]  handle_in;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  handle_out;
    logic [19:0] data_offset;
    logic        is_move;
    logic [19:0] move_source;
    logic [19:0] move_dest;
    logic [20:0] move_length;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [19:0] start;
    logic [19:0] payload;
    logic        is_free;
    logic [6:0]  next;
  } block_rec_t;

  typedef struct packed {
    logic [4:0] op;
    logic [2:0] status;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       req_zero;
    logic       hdl_bad;
    logic       hdl_inactive;
    logic       walk_end;
    logic       walk_end2;
    logic       fit;
    logic       slot_full;
    logic       slot_hit;
    logic       spare_none;
    logic       spare_hit;
    logic       split_ok;
    logic       c_nil;
    logic       merge;
    logic       d_free;
    logic       d_move;
    logic       tail_ok;
    logic       out_free;
  } dp_stat_t;

endpackage

// File: design/hchm_ram.sv
`timescale 1ns / 1ps
module hchm_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 65
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/hchm_ctrl.sv
`timescale 1ns / 1ps
module hchm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  hchm_pkg::dp_stat_t stat,
  output hchm_pkg::dp_cmd_t  cmd
);
  import hchm_pkg::*;

  localparam logic [4:0] S_BOOT   = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_DEC    = 5'd2;
  localparam logic [4:0] S_BUILD  = 5'd3;
  localparam logic [4:0] S_FIN    = 5'd4;
  localparam logic [4:0] S_AREAD  = 5'd5;
  localparam logic [4:0] S_ACHK   = 5'd6;
  localparam logic [4:0] S_SLOT   = 5'd7;
  localparam logic [4:0] S_ASPARE = 5'd8;
  localparam logic [4:0] S_SPLIT  = 5'd9;
  localparam logic [4:0] S_ACOMM  = 5'd10;
  localparam logic [4:0] S_AOK    = 5'd11;
  localparam logic [4:0] S_DOK    = 5'd12;
  localparam logic [4:0] S_FWR    = 5'd13;
  localparam logic [4:0] S_CINIT  = 5'd14;
  localparam logic [4:0] S_CRD    = 5'd15;
  localparam logic [4:0] S_CLAT   = 5'd16;
  localparam logic [4:0] S_CCHK   = 5'd17;
  localparam logic [4:0] S_DRD    = 5'd18;
  localparam logic [4:0] S_DLAT   = 5'd19;
  localparam logic [4:0] S_DPROC  = 5'd20;
  localparam logic [4:0] S_DMOVE  = 5'd21;
  localparam logic [4:0] S_DUPD   = 5'd22;
  localparam logic [4:0] S_DTAIL  = 5'd23;
  localparam logic [4:0] S_DSPARE = 5'd24;
  localparam logic [4:0] S_DFWR   = 5'd25;
  localparam logic [4:0] S_DLINK  = 5'd26;

  logic [4:0] state_r, state_nxt;
  logic [2:0] st_r, st_nxt;

  always_comb begin
    state_nxt  = state_r;
    st_nxt     = st_r;
    cmd.op     = OP_NOP;
    cmd.status = st_r;
    unique case (state_r)
      S_BOOT: begin
        cmd.op    = OP_BUILD;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_TAKE;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        priority if (stat.cmd == CMD_ALLOC) begin
          if (stat.req_zero) begin
            st_nxt    = ST_INVALID;
            state_nxt = S_FIN;
          end else begin
            cmd.op    = OP_WALK_INIT;
            state_nxt = S_AREAD;
          end
        end else if (stat.cmd == CMD_FREE || stat.cmd == CMD_DEREF) begin
          if (stat.hdl_bad) begin
            st_nxt    = ST_INVALID;
            state_nxt = S_FIN;
          end else if (stat.hdl_inactive) begin
            st_nxt    = ST_NOT_ACTIVE;
            state_nxt = S_FIN;
          end else begin
            cmd.op    = OP_RD_SLOT;
            state_nxt = (stat.cmd == CMD_DEREF) ? S_DOK : S_FWR;
          end
        end else if (stat.cmd == CMD_DEFRAG) begin
          cmd.op    = OP_WALK_INIT;
          state_nxt = S_DRD;
        end else if (stat.cmd == CMD_INIT) begin
          state_nxt = S_BUILD;
        end else begin
          st_nxt    = ST_INVALID;
          state_nxt = S_FIN;
        end
      end
      S_BUILD: begin
        cmd.op    = OP_BUILD;
        st_nxt    = ST_OK;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.op    = OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      S_AREAD: begin
        if (stat.walk_end) begin
          st_nxt    = ST_NO_SPACE;
          state_nxt = S_FIN;
        end else begin
          cmd.op    = OP_RD_E;
          state_nxt = S_ACHK;
        end
      end
      S_ACHK: begin
        cmd.op    = OP_AF_CHK;
        state_nxt = stat.fit ? S_SLOT : S_AREAD;
      end
      S_SLOT: begin
        if (stat.slot_full) begin
          st_nxt    = ST_NO_SLOT;
          state_nxt = S_FIN;
        end else begin
          cmd.op = OP_SLOT_STEP;
          if (stat.slot_hit) begin
            state_nxt = stat.split_ok ? S_ASPARE : S_ACOMM;
          end
        end
      end
      S_ASPARE: begin
        cmd.op = OP_SPARE_STEP;
        if (stat.spare_none) begin
          state_nxt = S_ACOMM;
        end else if (stat.spare_hit) begin
          state_nxt = S_SPLIT;
        end
      end
      S_SPLIT: begin
        cmd.op    = OP_SPLIT;
        state_nxt = S_ACOMM;
      end
      S_ACOMM: begin
        cmd.op    = OP_ACOMMIT;
        state_nxt = S_AOK;
      end
      S_AOK: begin
        if (stat.out_free) begin
          cmd.op    = OP_EMIT_ALLOC;
          state_nxt = S_IDLE;
        end
      end
      S_DOK: begin
        if (stat.out_free) begin
          cmd.op    = OP_EMIT_DEREF;
          state_nxt = S_IDLE;
        end
      end
      S_FWR: begin
        cmd.op    = OP_FREE_WR;
        state_nxt = S_CINIT;
      end
      S_CINIT: begin
        cmd.op    = OP_WALK_INIT;
        state_nxt = S_CRD;
      end
      S_CRD: begin
        if (stat.walk_end2) begin
          st_nxt    = ST_OK;
          state_nxt = S_FIN;
        end else begin
          cmd.op    = OP_RD_E;
          state_nxt = S_CLAT;
        end
      end
      S_CLAT: begin
        cmd.op = OP_C_LAT;
        if (stat.c_nil) begin
          st_nxt    = ST_OK;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_CCHK;
        end
      end
      S_CCHK: begin
        cmd.op    = OP_C_CHK;
        state_nxt = S_CRD;
      end
      S_DRD: begin
        if (stat.walk_end) begin
          state_nxt = S_DTAIL;
        end else begin
          cmd.op    = OP_RD_E;
          state_nxt = S_DLAT;
        end
      end
      S_DLAT: begin
        cmd.op    = OP_D_LAT;
        state_nxt = S_DPROC;
      end
      S_DPROC: begin
        if (stat.d_free) begin
          cmd.op    = OP_D_FREE;
          state_nxt = S_DRD;
        end else begin
          state_nxt = stat.d_move ? S_DMOVE : S_DUPD;
        end
      end
      S_DMOVE: begin
        if (stat.out_free) begin
          cmd.op    = OP_EMIT_MOVE;
          state_nxt = S_DUPD;
        end
      end
      S_DUPD: begin
        cmd.op    = OP_D_UPD;
        state_nxt = S_DRD;
      end
      S_DTAIL: begin
        cmd.op    = OP_D_TAIL;
        state_nxt = stat.tail_ok ? S_DSPARE : S_DLINK;
      end
      S_DSPARE: begin
        cmd.op = OP_SPARE_STEP;
        if (stat.spare_none) begin
          state_nxt = S_DLINK;
        end else if (stat.spare_hit) begin
          state_nxt = S_DFWR;
        end
      end
      S_DFWR: begin
        cmd.op    = OP_D_FWR;
        state_nxt = S_DLINK;
      end
      S_DLINK: begin
        cmd.op    = OP_D_LINK;
        st_nxt    = ST_OK;
        state_nxt = S_FIN;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_BOOT;
      st_r    <= ST_OK;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
    end
  end

endmodule

// File: design/hchm_dp.sv
`timescale 1ns / 1ps
module hchm_dp #(
  parameter int SLOT_COUNT    = hchm_pkg::SLOT_COUNT_DEF,
  parameter int BLOCK_ENTRIES = hchm_pkg::BLOCK_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [20:0]         cfg_wdata,
  input  hchm_pkg::in_item_t  in_item,
  input  hchm_pkg::dp_cmd_t   cmd,
  output hchm_pkg::dp_stat_t  stat,
  output logic                out_valid,
  input  logic                out_stall,
  output hchm_pkg::out_item_t out_item
);
  import hchm_pkg::*;

  localparam int N   = BLOCK_ENTRIES;
  localparam int S   = SLOT_COUNT;
  localparam int AW  = $clog2(N);
  localparam int SW  = (S > 1) ? $clog2(S) : 1;
  localparam int SCW = $clog2(((N > S) ? N : S) + 1);
  localparam int KW  = $clog2(S + 1);
  localparam int RW  = $bits(block_rec_t);

  localparam logic [19:0] HDR20 = 20'(HEADER_BYTES);
  localparam logic [20:0] HDR21 = 21'(HEADER_BYTES);
  localparam logic [21:0] HDR22 = 22'(HEADER_BYTES);

  logic [20:0]    heap_size_r, heap_size_nxt;
  logic [20:0]    heap_total_r, heap_total_nxt;
  logic [6:0]     list_head_r, list_head_nxt;
  logic [N-1:0]   in_use_r, in_use_nxt;
  logic [S-1:0]   slot_act_r, slot_act_nxt;
  logic [6:0]     slot_blk_r [S];
  logic [6:0]     slot_blk_nxt [S];
  logic [2:0]     cmd_r, cmd_nxt;
  logic [21:0]    sz_r, sz_nxt;
  logic           req_zero_r, req_zero_nxt;
  logic [5:0]     hdl_r, hdl_nxt;
  logic [6:0]     e_r, e_nxt;
  logic [6:0]     c_r, c_nxt;
  logic [7:0]     guard_r, guard_nxt;
  block_rec_t     rec_r, rec_nxt;
  logic [SCW-1:0] scan_r, scan_nxt;
  logic [5:0]     slot_r, slot_nxt;
  logic [6:0]     spare_r, spare_nxt;
  logic [21:0]    write_r, write_nxt;
  logic [6:0]     prev_r, prev_nxt;
  logic [6:0]     head_r, head_nxt;
  logic [KW-1:0]  k_r, k_nxt;
  logic [19:0]    pv_start_r, pv_start_nxt;
  logic [19:0]    pv_pay_r, pv_pay_nxt;
  logic           out_valid_r, out_valid_nxt;
  out_item_t      out_r, out_nxt;

  logic           ram_we, ram_re;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  logic [RW-1:0]  ram_wdata, ram_rdata;
  block_rec_t     wr_rec, rd_rec;

  logic [21:0]    hs_round;
  logic [20:0]    htot;
  logic [19:0]    remain_a;
  logic [21:0]    remain_t;
  logic           out_free;

  hchm_ram #(
    .WIDTH(RW),
    .DEPTH(N)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign ram_wdata = wr_rec;
  assign rd_rec    = block_rec_t'(ram_rdata);

  always_comb begin
    hs_round = ({1'b0, heap_size_r} + 22'd7) & ~22'd7;
    if (hs_round < HEAP_MIN) begin
      htot = 21'(HEAP_MIN);
    end else if (hs_round > HEAP_MAX) begin
      htot = 21'(HEAP_MAX);
    end else begin
      htot = hs_round[20:0];
    end
  end

  assign remain_a = rec_r.payload - sz_r[19:0];
  assign remain_t = ({1'b0, heap_total_r} > write_r) ? ({1'b0, heap_total_r} - write_r) : '0;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    stat.cmd          = cmd_r;
    stat.req_zero     = req_zero_r;
    stat.hdl_bad      = ({1'b0, hdl_r} >= 7'(S));
    stat.hdl_inactive = ({1'b0, hdl_r} < 7'(S)) &&
                        (!slot_act_r[hdl_r[SW-1:0]] || slot_blk_r[hdl_r[SW-1:0]] >= 7'(N));
    stat.walk_end     = (e_r >= 7'(N)) || (guard_r >= 8'(N));
    stat.walk_end2    = (e_r >= 7'(N)) || (guard_r >= 8'(2 * N));
    stat.fit          = rd_rec.is_free && ({2'b0, rd_rec.payload} >= sz_r);
    stat.slot_full    = (scan_r >= SCW'(S));
    stat.slot_hit     = (scan_r < SCW'(S)) && !slot_act_r[scan_r[SW-1:0]];
    stat.spare_none   = (scan_r >= SCW'(N));
    stat.spare_hit    = (scan_r < SCW'(N)) && !in_use_r[scan_r[AW-1:0]];
    stat.split_ok     = (remain_a >= 20'(SPLIT_MIN));
    stat.c_nil        = (rd_rec.next >= 7'(N));
    stat.merge        = rec_r.is_free && rd_rec.is_free;
    stat.d_free       = rec_r.is_free;
    stat.d_move       = ({2'b0, rec_r.start} != write_r) && (k_r < KW'(S));
    stat.tail_ok      = (remain_t >= 22'(SPLIT_MIN));
    stat.out_free     = out_free;
  end

  always_comb begin
    heap_total_nxt = heap_total_r;
    list_head_nxt  = list_head_r;
    in_use_nxt     = in_use_r;
    slot_act_nxt   = slot_act_r;
    slot_blk_nxt   = slot_blk_r;
    cmd_nxt        = cmd_r;
    sz_nxt         = sz_r;
    req_zero_nxt   = req_zero_r;
    hdl_nxt        = hdl_r;
    e_nxt          = e_r;
    c_nxt          = c_r;
    guard_nxt      = guard_r;
    rec_nxt        = rec_r;
    scan_nxt       = scan_r;
    slot_nxt       = slot_r;
    spare_nxt      = spare_r;
    write_nxt      = write_r;
    prev_nxt       = prev_r;
    head_nxt       = head_r;
    k_nxt          = k_r;
    pv_start_nxt   = pv_start_r;
    pv_pay_nxt     = pv_pay_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_nxt        = out_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    wr_rec         = rec_r;
    ram_re         = 1'b0;
    ram_raddr      = e_r[AW-1:0];
    unique case (cmd.op)
      OP_TAKE: begin
        cmd_nxt      = in_item.command;
        sz_nxt       = ({1'b0, in_item.request_size} + 22'd7) & ~22'd7;
        req_zero_nxt = (in_item.request_size == '0);
        hdl_nxt      = in_item.handle_in;
      end
      OP_BUILD: begin
        heap_total_nxt = htot;
        list_head_nxt  = '0;
        in_use_nxt     = '0;
        in_use_nxt[0]  = 1'b1;
        slot_act_nxt   = '0;
        ram_we         = 1'b1;
        ram_waddr      = '0;
        wr_rec.start   = '0;
        wr_rec.payload = 20'(htot - HDR21);
        wr_rec.is_free = 1'b1;
        wr_rec.next    = ENTRY_NIL;
      end
      OP_EMIT: begin
        out_valid_nxt  = 1'b1;
        out_nxt        = '0;
        out_nxt.status = cmd.status;
        out_nxt.last   = 1'b1;
      end
      OP_WALK_INIT: begin
        e_nxt     = list_head_r;
        guard_nxt = '0;
        write_nxt = '0;
        prev_nxt  = ENTRY_NIL;
        head_nxt  = ENTRY_NIL;
        k_nxt     = '0;
      end
      OP_RD_E: begin
        ram_re    = 1'b1;
        ram_raddr = e_r[AW-1:0];
      end
      OP_AF_CHK: begin
        if (stat.fit) begin
          rec_nxt  = rd_rec;
          c_nxt    = e_r;
          scan_nxt = '0;
        end else begin
          e_nxt     = rd_rec.next;
          guard_nxt = guard_r + 8'd1;
        end
      end
      OP_SLOT_STEP: begin
        if (stat.slot_hit) begin
          slot_nxt = 6'(scan_r);
          scan_nxt = '0;
        end else begin
          scan_nxt = scan_r + SCW'(1);
        end
      end
      OP_SPARE_STEP: begin
        if (stat.spare_none) begin
          spare_nxt = ENTRY_NIL;
        end else if (stat.spare_hit) begin
          spare_nxt = 7'(scan_r);
        end else begin
          scan_nxt = scan_r + SCW'(1);
        end
      end
      OP_SPLIT: begin
        ram_we         = 1'b1;
        ram_waddr      = spare_r[AW-1:0];
        wr_rec.start   = 20'({2'b0, rec_r.start} + HDR22 + sz_r);
        wr_rec.payload = remain_a - HDR20;
        wr_rec.is_free = 1'b1;
        wr_rec.next    = rec_r.next;
        in_use_nxt[spare_r[AW-1:0]] = 1'b1;
        rec_nxt.payload = sz_r[19:0];
        rec_nxt.next    = spare_r;
      end
      OP_ACOMMIT: begin
        ram_we         = 1'b1;
        ram_waddr      = c_r[AW-1:0];
        wr_rec         = rec_r;
        wr_rec.is_free = 1'b0;
        slot_act_nxt[slot_r[SW-1:0]] = 1'b1;
        slot_blk_nxt[slot_r[SW-1:0]] = c_r;
      end
      OP_EMIT_ALLOC: begin
        out_valid_nxt       = 1'b1;
        out_nxt             = '0;
        out_nxt.status      = ST_OK;
        out_nxt.handle_out  = slot_r;
        out_nxt.data_offset = rec_r.start + HDR20;
        out_nxt.last        = 1'b1;
      end
      OP_RD_SLOT: begin
        ram_re    = 1'b1;
        ram_raddr = slot_blk_r[hdl_r[SW-1:0]][AW-1:0];
        c_nxt     = slot_blk_r[hdl_r[SW-1:0]];
      end
      OP_EMIT_DEREF: begin
        out_valid_nxt       = 1'b1;
        out_nxt             = '0;
        out_nxt.status      = ST_OK;
        out_nxt.data_offset = rd_rec.start + HDR20;
        out_nxt.last        = 1'b1;
      end
      OP_FREE_WR: begin
        ram_we         = 1'b1;
        ram_waddr      = c_r[AW-1:0];
        wr_rec         = rd_rec;
        wr_rec.is_free = 1'b1;
        slot_act_nxt[hdl_r[SW-1:0]] = 1'b0;
      end
      OP_C_LAT: begin
        rec_nxt   = rd_rec;
        guard_nxt = guard_r + 8'd1;
        ram_re    = !stat.c_nil;
        ram_raddr = rd_rec.next[AW-1:0];
      end
      OP_C_CHK: begin
        if (stat.merge) begin
          ram_we         = 1'b1;
          ram_waddr      = e_r[AW-1:0];
          wr_rec.start   = rec_r.start;
          wr_rec.payload = rec_r.payload + HDR20 + rd_rec.payload;
          wr_rec.is_free = 1'b1;
          wr_rec.next    = rd_rec.next;
          in_use_nxt[rec_r.next[AW-1:0]] = 1'b0;
        end else begin
          e_nxt = rec_r.next;
        end
      end
      OP_D_LAT: begin
        rec_nxt   = rd_rec;
        c_nxt     = e_r;
        e_nxt     = rd_rec.next;
        guard_nxt = guard_r + 8'd1;
      end
      OP_D_FREE: begin
        in_use_nxt[c_r[AW-1:0]] = 1'b0;
      end
      OP_EMIT_MOVE: begin
        out_valid_nxt       = 1'b1;
        out_nxt             = '0;
        out_nxt.status      = ST_OK;
        out_nxt.is_move     = 1'b1;
        out_nxt.move_source = rec_r.start;
        out_nxt.move_dest   = write_r[19:0];
        out_nxt.move_length = HDR21 + {1'b0, rec_r.payload};
        out_nxt.last        = 1'b0;
        k_nxt               = k_r + KW'(1);
      end
      OP_D_UPD: begin
        if (prev_r < 7'(N)) begin
          ram_we         = 1'b1;
          ram_waddr      = prev_r[AW-1:0];
          wr_rec.start   = pv_start_r;
          wr_rec.payload = pv_pay_r;
          wr_rec.is_free = 1'b0;
          wr_rec.next    = c_r;
        end else begin
          head_nxt = c_r;
        end
        pv_start_nxt = write_r[19:0];
        pv_pay_nxt   = rec_r.payload;
        prev_nxt     = c_r;
        write_nxt    = write_r + HDR22 + {2'b0, rec_r.payload};
      end
      OP_D_TAIL: begin
        spare_nxt = ENTRY_NIL;
        scan_nxt  = '0;
      end
      OP_D_FWR: begin
        ram_we         = 1'b1;
        ram_waddr      = spare_r[AW-1:0];
        wr_rec.start   = write_r[19:0];
        wr_rec.payload = 20'(remain_t - HDR22);
        wr_rec.is_free = 1'b1;
        wr_rec.next    = ENTRY_NIL;
        in_use_nxt[spare_r[AW-1:0]] = 1'b1;
      end
      OP_D_LINK: begin
        if (prev_r < 7'(N)) begin
          ram_we         = 1'b1;
          ram_waddr      = prev_r[AW-1:0];
          wr_rec.start   = pv_start_r;
          wr_rec.payload = pv_pay_r;
          wr_rec.is_free = 1'b0;
          wr_rec.next    = spare_r;
          list_head_nxt  = head_r;
        end else begin
          list_head_nxt = spare_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    heap_size_nxt = cfg_we ? cfg_wdata : heap_size_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_size_r <= HEAP_SIZE_RST;
      list_head_r <= '0;
      in_use_r    <= N'(1);
      slot_act_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      heap_size_r <= heap_size_nxt;
      list_head_r <= list_head_nxt;
      in_use_r    <= in_use_nxt;
      slot_act_r  <= slot_act_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    heap_total_r <= heap_total_nxt;
    slot_blk_r   <= slot_blk_nxt;
    cmd_r        <= cmd_nxt;
    sz_r         <= sz_nxt;
    req_zero_r   <= req_zero_nxt;
    hdl_r        <= hdl_nxt;
    e_r          <= e_nxt;
    c_r          <= c_nxt;
    guard_r      <= guard_nxt;
    rec_r        <= rec_nxt;
    scan_r       <= scan_nxt;
    slot_r       <= slot_nxt;
    spare_r      <= spare_nxt;
    write_r      <= write_nxt;
    prev_r       <= prev_nxt;
    head_r       <= head_nxt;
    k_r          <= k_nxt;
    pv_start_r   <= pv_start_nxt;
    pv_pay_r     <= pv_pay_nxt;
    out_r        <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

`ifndef SYNTH
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_EMIT || cmd.op == OP_EMIT_ALLOC || cmd.op == OP_EMIT_DEREF ||
     cmd.op == OP_EMIT_MOVE) |-> out_free)
    else $error("result issued while output register occupied");
  a_build_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_BUILD) |=> (list_head_r == '0 && slot_act_r == '0 && in_use_r == N'(1)))
    else $error("build left stale list or slot state");
  a_move_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.is_move) |-> !out_r.last)
    else $error("move descriptor flagged as last");
  a_move_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_EMIT_MOVE) |-> (k_r < KW'(S)))
    else $error("move count exceeds slot count");
`endif

endmodule

// File: design/handle_compacting_heap_manager.sv
// Steps from acceptance to result: deref reads the slot's entry, init rebuilds the free block;
// alloc walks the list entries, scans the slots and, when it splits, scans for a spare entry;
// free writes the block free and then walks the list merging free neighbours; defrag walks every
// entry, emitting a move for each allocated entry it relocates, then scans for a spare tail entry.
// Throughput: one transaction at a time; the next can be accepted in the cycle that the final result is presented.
// Reset: synchronous, active low; the first cycle after reset builds the initial free block.
`timescale 1ns / 1ps
module handle_compacting_heap_manager #(
  parameter int SLOT_COUNT    = hchm_pkg::SLOT_COUNT_DEF,
  parameter int BLOCK_ENTRIES = hchm_pkg::BLOCK_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  hchm_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output hchm_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [20:0]         cfg_wdata
);
  import hchm_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  hchm_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .stat    (dp_stat),
    .cmd     (dp_cmd)
  );

  hchm_dp #(
    .SLOT_COUNT   (SLOT_COUNT),
    .BLOCK_ENTRIES(BLOCK_ENTRIES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_item  (in_item),
    .cmd      (dp_cmd),
    .stat     (dp_stat),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

endmodule
